// File: hdl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the bitmap page allocator: request and
// status codes, field widths and the controller to datapath interface.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int FUNC_W  = 3;
  localparam int IDX_W   = 12;
  localparam int SEQ_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 13;
  localparam int WORD_W  = 64;
  localparam int BIT_W   = 6;

  localparam logic [FUNC_W-1:0] FN_ALLOC      = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DISPOSE    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RECOVER    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REDO_ALLOC = 3'd3;
  localparam logic [FUNC_W-1:0] FN_REDO_FREE  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CHECK      = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ERR     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd3;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic lookup;
    logic scan_start;
    logic scan_step;
    logic eval_commit;
    logic alloc_commit;
  } bpa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_needed;
    logic hit;
    logic chk_last;
  } bpa_sts_t;

endpackage

// File: hdl/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Controller of the bitmap page allocator: sequences the clearing pass, the
// single-word lookups, the bitmap scan and the output beat handshake.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_CLEAR      = 6'b000001,
    S_IDLE       = 6'b000010,
    S_LOOKUP     = 6'b000100,
    S_EVAL       = 6'b001000,
    S_SCAN_START = 6'b010000,
    S_SCAN       = 6'b100000
  } bpa_state_t;

  bpa_state_t state;
  bpa_state_t state_next;
  logic       out_free;
  logic       out_valid_next;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.scan_needed ? S_SCAN_START : S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          cmd.eval_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SCAN_START: begin
        cmd.scan_start = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        if (sts.hit) begin
          if (out_free) begin
            cmd.alloc_commit = 1'b1;
            state_next       = S_IDLE;
          end
        end else if (sts.chk_last) begin
          state_next = S_LOOKUP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.eval_commit || cmd.alloc_commit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: hdl/bpa_dpath.sv
// ----------------------------------------------------------------------------
// bpa_dpath
// Datapath of the bitmap page allocator: bitmap memory of 64-bit words,
// page counts, header sequence number, free-bit search and request decode.
// ----------------------------------------------------------------------------
module bpa_dpath #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bpa_pkg::FUNC_W-1:0]   func,
  input  logic [bpa_pkg::IDX_W-1:0]    page_index,
  input  logic [bpa_pkg::SEQ_W-1:0]    log_seq,
  input  bpa_pkg::bpa_cmd_t            cmd,
  output bpa_pkg::bpa_sts_t            sts,
  output logic [bpa_pkg::STAT_W-1:0]   status,
  output logic [bpa_pkg::IDX_W-1:0]    granted_page,
  output logic                         extended,
  output logic [bpa_pkg::CNT_W-1:0]    used_pages,
  output logic [bpa_pkg::CNT_W-1:0]    total_pages
);

  localparam int WORDS = (MAX_PAGES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(MAX_PAGES + 1);
  localparam int XW    = (CW > bpa_pkg::IDX_W) ? CW : bpa_pkg::IDX_W;
  localparam int GW    = AW + bpa_pkg::BIT_W;
  localparam logic [CW-1:0] MAXC  = CW'(MAX_PAGES);
  localparam logic [XW-1:0] MAXX  = XW'(MAX_PAGES);
  localparam logic [AW-1:0] LASTW = AW'(WORDS - 1);

  logic [bpa_pkg::WORD_W-1:0] mem [WORDS];
  logic [bpa_pkg::WORD_W-1:0] rdata;

  logic [CW-1:0]              used;
  logic [CW-1:0]              total;
  logic [bpa_pkg::SEQ_W-1:0]  hseq;
  logic [AW-1:0]              clear_addr;
  logic [AW-1:0]              chk_addr;
  logic [bpa_pkg::FUNC_W-1:0] func_r;
  logic [XW-1:0]              tgt;
  logic [bpa_pkg::SEQ_W-1:0]  seq_r;

  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [bpa_pkg::WORD_W-1:0] mem_wd;
  logic                       mem_re;
  logic [AW-1:0]              mem_ra;

  logic [XW-1:0]              lim;
  logic [AW-1:0]              last_word;
  logic [AW-1:0]              tgt_word;
  logic [bpa_pkg::WORD_W-1:0] vmask;
  logic [bpa_pkg::WORD_W-1:0] free;
  logic [bpa_pkg::BIT_W-1:0]  pos;
  logic                       hit;
  logic [GW-1:0]              hit_page;

  logic                       tgt_ok;
  logic                       tgt_bit;
  logic                       tgt_lt;
  logic                       tgt_eq;
  logic                       is_full;
  logic                       seq_new;
  logic [bpa_pkg::WORD_W-1:0] tgt_mask;

  logic [bpa_pkg::STAT_W-1:0] e_stat;
  logic [bpa_pkg::IDX_W-1:0]  e_gr;
  logic                       e_ext;
  logic [CW-1:0]              e_used;
  logic [CW-1:0]              e_total;
  logic [bpa_pkg::SEQ_W-1:0]  e_hseq;
  logic                       e_wr;
  logic                       e_set;

  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
    return (v < MAXC) ? v + 1'b1 : v;
  endfunction

  function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
    return (v != '0) ? v - 1'b1 : v;
  endfunction

  // free-bit search over the word under check
  assign lim       = XW'(total) - 1'b1;
  assign last_word = AW'(lim >> bpa_pkg::BIT_W);
  assign tgt_word  = AW'(tgt >> bpa_pkg::BIT_W);

  always_comb begin
    for (int k = 0; k < bpa_pkg::WORD_W; k++) begin
      vmask[k] = (chk_addr != last_word) || (bpa_pkg::BIT_W'(k) <= lim[bpa_pkg::BIT_W-1:0]);
    end
    free = ~rdata & vmask;
    pos  = '0;
    for (int k = bpa_pkg::WORD_W - 1; k >= 0; k--) begin
      if (free[k]) begin
        pos = bpa_pkg::BIT_W'(k);
      end
    end
  end

  assign hit      = |free;
  assign hit_page = {chk_addr, pos};

  assign sts.clear_last  = (clear_addr == LASTW);
  assign sts.scan_needed = (func == bpa_pkg::FN_ALLOC) && (used < total);
  assign sts.hit         = hit;
  assign sts.chk_last    = (chk_addr == last_word);

  // single-page request decode
  assign tgt_ok   = (tgt < MAXX);
  assign tgt_bit  = tgt_ok && rdata[tgt[bpa_pkg::BIT_W-1:0]];
  assign tgt_lt   = (tgt < XW'(total));
  assign tgt_eq   = (tgt == XW'(total));
  assign is_full  = (total >= MAXC);
  assign seq_new  = (hseq < seq_r);
  assign tgt_mask = bpa_pkg::WORD_W'(1) << tgt[bpa_pkg::BIT_W-1:0];

  always_comb begin
    e_stat  = bpa_pkg::STAT_OK;
    e_gr    = '0;
    e_ext   = 1'b0;
    e_used  = used;
    e_total = total;
    e_hseq  = hseq;
    e_wr    = 1'b0;
    e_set   = 1'b0;
    case (func_r)
      bpa_pkg::FN_ALLOC: begin
        if (is_full) begin
          e_stat = bpa_pkg::STAT_FULL;
        end else begin
          e_gr    = bpa_pkg::IDX_W'(tgt);
          e_ext   = 1'b1;
          e_used  = inc_sat(used);
          e_total = inc_sat(total);
          e_wr    = 1'b1;
          e_set   = 1'b1;
        end
      end
      bpa_pkg::FN_DISPOSE: begin
        if (tgt == '0) begin
          e_stat = bpa_pkg::STAT_ERR;
        end else if (!tgt_ok) begin
          e_stat = bpa_pkg::STAT_INVALID;
        end else if (tgt_bit) begin
          e_used = dec_sat(used);
          e_wr   = 1'b1;
        end
      end
      bpa_pkg::FN_RECOVER: begin
        if (!tgt_ok) begin
          e_stat = bpa_pkg::STAT_INVALID;
        end else if (!tgt_bit) begin
          e_used  = inc_sat(used);
          e_total = inc_sat(total);
          e_wr    = 1'b1;
          e_set   = 1'b1;
        end
      end
      bpa_pkg::FN_REDO_ALLOC: begin
        if (seq_new) begin
          if (tgt_lt) begin
            if (!tgt_bit) begin
              e_used = inc_sat(used);
              e_wr   = 1'b1;
              e_set  = 1'b1;
            end
          end else if (!tgt_eq || is_full) begin
            e_stat = bpa_pkg::STAT_ERR;
          end else begin
            e_used  = inc_sat(used);
            e_total = inc_sat(total);
            e_hseq  = seq_r;
            e_wr    = 1'b1;
            e_set   = 1'b1;
          end
        end
      end
      bpa_pkg::FN_REDO_FREE: begin
        if (seq_new) begin
          if (!tgt_lt || !tgt_bit) begin
            e_stat = bpa_pkg::STAT_ERR;
          end else begin
            e_used = dec_sat(used);
            e_hseq = seq_r;
            e_wr   = 1'b1;
          end
        end
      end
      bpa_pkg::FN_CHECK: begin
        if (!tgt_lt || !tgt_bit) begin
          e_stat = bpa_pkg::STAT_INVALID;
        end
      end
      default: begin
        e_stat = bpa_pkg::STAT_ERR;
      end
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clear_addr;
    mem_wd = (clear_addr == '0) ? bpa_pkg::WORD_W'(1) : '0;
    if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (cmd.eval_commit && e_wr) begin
      mem_we = 1'b1;
      mem_wa = tgt_word;
      mem_wd = e_set ? (rdata | tgt_mask) : (rdata & ~tgt_mask);
    end else if (cmd.alloc_commit) begin
      mem_we = 1'b1;
      mem_wa = chk_addr;
      mem_wd = rdata | (bpa_pkg::WORD_W'(1) << pos);
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = tgt_word;
    if (cmd.lookup && tgt_ok) begin
      mem_re = 1'b1;
    end else if (cmd.scan_start) begin
      mem_re = 1'b1;
      mem_ra = '0;
    end else if (cmd.scan_step) begin
      mem_re = 1'b1;
      mem_ra = chk_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata <= mem[mem_ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= CW'(1);
      total      <= CW'(1);
      hseq       <= '0;
      clear_addr <= '0;
    end else begin
      if (cmd.clear_wr && !sts.clear_last) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (cmd.eval_commit) begin
        used  <= e_used;
        total <= e_total;
        hseq  <= e_hseq;
      end else if (cmd.alloc_commit) begin
        used <= inc_sat(used);
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      seq_r  <= log_seq;
      tgt    <= (func == bpa_pkg::FN_ALLOC) ? XW'(total) : XW'(page_index);
    end
    if (cmd.scan_start) begin
      chk_addr <= '0;
    end else if (cmd.scan_step) begin
      chk_addr <= chk_addr + 1'b1;
    end
    if (cmd.eval_commit) begin
      status       <= e_stat;
      granted_page <= e_gr;
      extended     <= e_ext;
      used_pages   <= bpa_pkg::CNT_W'(e_used);
      total_pages  <= bpa_pkg::CNT_W'(e_total);
    end else if (cmd.alloc_commit) begin
      status       <= bpa_pkg::STAT_OK;
      granted_page <= bpa_pkg::IDX_W'(hit_page);
      extended     <= 1'b0;
      used_pages   <= bpa_pkg::CNT_W'(inc_sat(used));
      total_pages  <= bpa_pkg::CNT_W'(total);
    end
  end

endmodule

// File: hdl/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// Page allocation bitmap with allocated count, page count and header
// sequence number; serves allocate, dispose, recover, redo and check.
// ----------------------------------------------------------------------------
// After reset the bitmap is cleared one 64-bit word per cycle, ceil(MAX_PAGES/64)
// words (64 at the default), during which no request is taken; the store then
// holds only page 0. Dispose, recover, redo and check load the request, read
// the bitmap word, then, once the output register is free, update the word and
// register the result beat. Allocate searches the bitmap one word per cycle
// from page 0, up to ceil(total/64) words (64 at the default); when no free page
// is found below the page count it appends a page. When every page below the
// page count is in use it skips the search and appends; an append reports full
// once the page count is MAX_PAGES. The result is held in an output register,
// so the next request is taken while a result beat waits on out_stall.
module bitmap_page_allocator #(
  parameter int MAX_PAGES = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bpa_pkg::FUNC_W-1:0]   func,
  input  logic [bpa_pkg::IDX_W-1:0]    page_index,
  input  logic [bpa_pkg::SEQ_W-1:0]    log_seq,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bpa_pkg::STAT_W-1:0]   status,
  output logic [bpa_pkg::IDX_W-1:0]    granted_page,
  output logic                         extended,
  output logic [bpa_pkg::CNT_W-1:0]    used_pages,
  output logic [bpa_pkg::CNT_W-1:0]    total_pages
);

  bpa_pkg::bpa_cmd_t cmd;
  bpa_pkg::bpa_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dpath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .func         (func),
    .page_index   (page_index),
    .log_seq      (log_seq),
    .cmd          (cmd),
    .sts          (sts),
    .status       (status),
    .granted_page (granted_page),
    .extended     (extended),
    .used_pages   (used_pages),
    .total_pages  (total_pages)
  );

endmodule
